### rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared codes, bounds and calendar helpers for the calendar date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam logic [2:0] KIND_QUERY         = 3'd0;
    localparam logic [2:0] KIND_STEP_DAYS     = 3'd1;
    localparam logic [2:0] KIND_STEP_MONTHS   = 3'd2;
    localparam logic [2:0] KIND_STEP_HOURS    = 3'd3;
    localparam logic [2:0] KIND_SET_DATE      = 3'd4;
    localparam logic [2:0] KIND_SET_DATE_HOUR = 3'd5;
    localparam logic [2:0] KIND_END_SIM       = 3'd6;

    localparam logic [11:0] YEAR_MAX  = 12'd4095;
    localparam logic [11:0] VALID_LO  = 12'd1900;
    localparam logic [11:0] VALID_HI  = 12'd2100;
    localparam logic [3:0]  MONTHS    = 4'd12;
    localparam logic [4:0]  HOURS_DAY = 5'd24;

    // Highest linear month index, December of the last year.
    localparam logic [15:0] MONTH_IDX_MAX = 16'd49151;

    // Reciprocals for division by 25 (ten-bit operand) and by 3 (14-bit operand).
    localparam logic [10:0] RECIP_25 = 11'd1311;
    localparam logic [15:0] RECIP_3  = 16'd21846;

    function automatic logic is_leap(input logic [11:0] y);
        logic [9:0]  k;
        logic [20:0] prod;
        logic [5:0]  q;
        logic [9:0]  q25;
        logic        cent;
        k    = y[11:2];
        prod = k * RECIP_25;
        q    = prod[20:15];
        q25  = {q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q};
        cent = (k == q25);
        return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        unique case (m)
            4'd2:                     len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/calendar_date_stepper_core.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper_core
// Simulated calendar date and hour, stepped by days, months or hours.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its result
// appears for exactly one cycle with done high; the receiver cannot stall it,
// so it must take the beat in that cycle. Query, set and end commands go
// straight from idle to the finish state. A day step counts |amount| down,
// because one shared day-step unit moves the date by one day per cycle. An
// hour step moves the date once per 24-hour wrap, using the same unit. A
// month step runs linear month index, reciprocal division by twelve, day clamp.
module calendar_date_stepper_core
    import cds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [12:0] amount,
    input  logic [4:0]         date_day,
    input  logic [3:0]         date_month,
    input  logic [11:0]        date_year,
    input  logic [4:0]         hour_value,
    output logic               done,
    output logic [4:0]         cur_day,
    output logic [3:0]         cur_month,
    output logic [11:0]        cur_year,
    output logic [4:0]         cur_hour,
    output logic               sim_on,
    output logic               date_ok
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOURS,
        ST_MON_IDX,
        ST_MON_DIV,
        ST_MON_CLAMP,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [4:0]         sim_day_reg, sim_day_next;
    logic [3:0]         sim_month_reg, sim_month_next;
    logic [11:0]        sim_year_reg, sim_year_next;
    logic               sim_active_reg, sim_active_next;
    logic [4:0]         sim_hour_reg, sim_hour_next;
    logic               hour_held_reg, hour_held_next;
    logic [4:0]         in_day_reg, in_day_next;
    logic [3:0]         in_month_reg, in_month_next;
    logic [11:0]        in_year_reg, in_year_next;
    logic [4:0]         in_hour_reg, in_hour_next;
    logic signed [12:0] amt_reg, amt_next;
    logic [12:0]        cnt_reg, cnt_next;
    logic               dir_reg, dir_next;
    logic signed [13:0] hr_reg, hr_next;
    logic [15:0]        idx_reg, idx_next;
    logic               done_reg, done_next;
    logic [4:0]         cur_day_reg, cur_day_next;
    logic [3:0]         cur_month_reg, cur_month_next;
    logic [11:0]        cur_year_reg, cur_year_next;
    logic [4:0]         cur_hour_reg, cur_hour_next;
    logic               sim_on_reg, sim_on_next;
    logic               date_ok_reg, date_ok_next;

    logic [4:0]         base_day;
    logic [3:0]         base_month;
    logic [11:0]        base_year;
    logic               step_back;
    logic [4:0]         step_day;
    logic [3:0]         step_month;
    logic [11:0]        step_year;
    logic [5:0]         fwd_day;
    logic [4:0]         fwd_month;
    logic [3:0]         bwd_month;
    logic [11:0]        bwd_year;
    logic [4:0]         base_len;

    logic [17:0]        year_x12;
    logic signed [17:0] idx_raw;
    logic [29:0]        div_prod;
    logic [11:0]        div_q;
    logic [15:0]        div_q12;
    logic [15:0]        div_rem;
    logic [4:0]         clamp_len;
    logic [4:0]         out_len;
    logic [4:0]         hour_base;

    assign base_day   = sim_active_reg ? sim_day_reg   : in_day_reg;
    assign base_month = sim_active_reg ? sim_month_reg : in_month_reg;
    assign base_year  = sim_active_reg ? sim_year_reg  : in_year_reg;
    assign step_back  = (state_reg == ST_HOURS) ? hr_reg[13] : dir_reg;
    assign base_len   = month_len(base_month, base_year);

    // Shared day-step unit: moves the base date one day forward or back.
    always_comb
    begin
        fwd_day    = {1'b0, base_day} + 6'd1;
        fwd_month  = {1'b0, base_month} + 5'd1;
        bwd_month  = base_month;
        bwd_year   = base_year;
        step_day   = base_day;
        step_month = base_month;
        step_year  = base_year;
        if (!step_back) begin
            if (fwd_day > {1'b0, base_len}) begin
                if (fwd_month > {1'b0, MONTHS}) begin
                    if (base_year == YEAR_MAX) begin
                        step_day   = 5'd31;
                        step_month = MONTHS;
                    end
                    else begin
                        step_day   = 5'd1;
                        step_month = 4'd1;
                        step_year  = base_year + 12'd1;
                    end
                end
                else begin
                    step_day   = 5'd1;
                    step_month = fwd_month[3:0];
                end
            end
            else begin
                step_day = fwd_day[4:0];
            end
        end
        else begin
            if (base_day >= 5'd2) begin
                step_day = base_day - 5'd1;
            end
            else if (base_month <= 4'd1 && base_year == 12'd0) begin
                step_day   = 5'd1;
                step_month = 4'd1;
            end
            else begin
                if (base_month <= 4'd1) begin
                    bwd_month = MONTHS;
                    bwd_year  = base_year - 12'd1;
                end
                else begin
                    bwd_month = base_month - 4'd1;
                end
                step_month = bwd_month;
                step_year  = bwd_year;
                step_day   = month_len(bwd_month, bwd_year);
            end
        end
    end

    always_comb
    begin
        year_x12  = {3'd0, sim_year_reg, 3'd0} + {4'd0, sim_year_reg, 2'd0};
        idx_raw   = $signed(year_x12) + $signed({14'd0, sim_month_reg}) - 18'sd1
                    + $signed({{5{amt_reg[12]}}, amt_reg});
        div_prod  = idx_reg[15:2] * RECIP_3;
        div_q     = div_prod[27:16];
        div_q12   = {1'b0, div_q, 3'd0} + {2'd0, div_q, 2'd0};
        div_rem   = idx_reg - div_q12;
        clamp_len = month_len(sim_month_reg, sim_year_reg);
        out_len   = month_len(base_month, base_year);
        hour_base = hour_held_reg ? sim_hour_reg : hour_value;
    end

    always_comb
    begin
        state_next      = state_reg;
        sim_day_next    = sim_day_reg;
        sim_month_next  = sim_month_reg;
        sim_year_next   = sim_year_reg;
        sim_active_next = sim_active_reg;
        sim_hour_next   = sim_hour_reg;
        hour_held_next  = hour_held_reg;
        in_day_next     = in_day_reg;
        in_month_next   = in_month_reg;
        in_year_next    = in_year_reg;
        in_hour_next    = in_hour_reg;
        amt_next        = amt_reg;
        cnt_next        = cnt_reg;
        dir_next        = dir_reg;
        hr_next         = hr_reg;
        idx_next        = idx_reg;
        done_next       = 1'b0;
        cur_day_next    = cur_day_reg;
        cur_month_next  = cur_month_reg;
        cur_year_next   = cur_year_reg;
        cur_hour_next   = cur_hour_reg;
        sim_on_next     = sim_on_reg;
        date_ok_next    = date_ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    in_day_next   = date_day;
                    in_month_next = date_month;
                    in_year_next  = date_year;
                    in_hour_next  = hour_value;
                    amt_next      = amount;
                    state_next    = ST_FIN;
                    unique case (kind)
                        KIND_STEP_DAYS, KIND_STEP_MONTHS:
                        begin
                            if (!sim_active_reg) begin
                                sim_day_next    = date_day;
                                sim_month_next  = date_month;
                                sim_year_next   = date_year;
                                sim_active_next = 1'b1;
                            end
                            cnt_next   = amount[12] ? 13'(-amount) : 13'(amount);
                            dir_next   = amount[12];
                            state_next = (kind == KIND_STEP_DAYS) ? ST_DAYS : ST_MON_IDX;
                        end
                        KIND_STEP_HOURS:
                        begin
                            sim_hour_next  = hour_base;
                            hour_held_next = 1'b1;
                            hr_next        = $signed({9'd0, hour_base})
                                             + $signed({amount[12], amount});
                            state_next     = ST_HOURS;
                        end
                        KIND_SET_DATE, KIND_SET_DATE_HOUR:
                        begin
                            sim_day_next    = date_day;
                            sim_month_next  = date_month;
                            sim_year_next   = date_year;
                            sim_active_next = 1'b1;
                            if (kind == KIND_SET_DATE_HOUR) begin
                                sim_hour_next  = hour_value;
                                hour_held_next = 1'b1;
                            end
                        end
                        KIND_END_SIM:
                        begin
                            sim_active_next = 1'b0;
                            hour_held_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DAYS:
            begin
                if (cnt_reg == 13'd0) begin
                    state_next = ST_FIN;
                end
                else begin
                    sim_day_next   = step_day;
                    sim_month_next = step_month;
                    sim_year_next  = step_year;
                    cnt_next       = cnt_reg - 13'd1;
                end
            end
            ST_HOURS:
            begin
                if (hr_reg >= $signed({9'd0, HOURS_DAY})) begin
                    hr_next         = hr_reg - $signed({9'd0, HOURS_DAY});
                    sim_day_next    = step_day;
                    sim_month_next  = step_month;
                    sim_year_next   = step_year;
                    sim_active_next = 1'b1;
                end
                else if (hr_reg[13]) begin
                    hr_next         = hr_reg + $signed({9'd0, HOURS_DAY});
                    sim_day_next    = step_day;
                    sim_month_next  = step_month;
                    sim_year_next   = step_year;
                    sim_active_next = 1'b1;
                end
                else begin
                    sim_hour_next = hr_reg[4:0];
                    state_next    = ST_FIN;
                end
            end
            ST_MON_IDX:
            begin
                if (idx_raw[17]) begin
                    idx_next = 16'd0;
                end
                else if (idx_raw > $signed({2'd0, MONTH_IDX_MAX})) begin
                    idx_next = MONTH_IDX_MAX;
                end
                else begin
                    idx_next = idx_raw[15:0];
                end
                state_next = ST_MON_DIV;
            end
            ST_MON_DIV:
            begin
                sim_year_next  = div_q;
                sim_month_next = div_rem[3:0] + 4'd1;
                state_next     = ST_MON_CLAMP;
            end
            ST_MON_CLAMP:
            begin
                if (sim_day_reg > clamp_len) begin
                    sim_day_next = clamp_len;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cur_day_next   = base_day;
                cur_month_next = base_month;
                cur_year_next  = base_year;
                cur_hour_next  = hour_held_reg ? sim_hour_reg : in_hour_reg;
                sim_on_next    = sim_active_reg;
                date_ok_next   = (base_year >= VALID_LO) && (base_year <= VALID_HI)
                                 && (base_month >= 4'd1) && (base_month <= MONTHS)
                                 && (base_day >= 5'd1) && (base_day <= out_len);
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            sim_day_reg    <= 5'd1;
            sim_month_reg  <= 4'd1;
            sim_year_reg   <= VALID_LO;
            sim_active_reg <= 1'b0;
            sim_hour_reg   <= 5'd0;
            hour_held_reg  <= 1'b0;
            in_day_reg     <= 5'd0;
            in_month_reg   <= 4'd0;
            in_year_reg    <= 12'd0;
            in_hour_reg    <= 5'd0;
            amt_reg        <= 13'sd0;
            cnt_reg        <= 13'd0;
            dir_reg        <= 1'b0;
            hr_reg         <= 14'sd0;
            idx_reg        <= 16'd0;
            done_reg       <= 1'b0;
            cur_day_reg    <= 5'd0;
            cur_month_reg  <= 4'd0;
            cur_year_reg   <= 12'd0;
            cur_hour_reg   <= 5'd0;
            sim_on_reg     <= 1'b0;
            date_ok_reg    <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            sim_day_reg    <= sim_day_next;
            sim_month_reg  <= sim_month_next;
            sim_year_reg   <= sim_year_next;
            sim_active_reg <= sim_active_next;
            sim_hour_reg   <= sim_hour_next;
            hour_held_reg  <= hour_held_next;
            in_day_reg     <= in_day_next;
            in_month_reg   <= in_month_next;
            in_year_reg    <= in_year_next;
            in_hour_reg    <= in_hour_next;
            amt_reg        <= amt_next;
            cnt_reg        <= cnt_next;
            dir_reg        <= dir_next;
            hr_reg         <= hr_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            cur_day_reg    <= cur_day_next;
            cur_month_reg  <= cur_month_next;
            cur_year_reg   <= cur_year_next;
            cur_hour_reg   <= cur_hour_next;
            sim_on_reg     <= sim_on_next;
            date_ok_reg    <= date_ok_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign cur_day   = cur_day_reg;
    assign cur_month = cur_month_reg;
    assign cur_year  = cur_year_reg;
    assign cur_hour  = cur_hour_reg;
    assign sim_on    = sim_on_reg;
    assign date_ok   = date_ok_reg;

endmodule

### bench/calendar_date_stepper_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_stepper_core_test
// Self-checking bench for the calendar date stepper core.
// A short list of directed commands covers the field extremes, every command
// kind, the year bounds, out-of-range dates and hours, and the real-clock
// fallback. A long random run follows. Every result beat is compared, field
// by field, with the in-bench calendar predictor, which tracks the simulated
// date and hour, or with the expected beat written in its directed row.
// ----------------------------------------------------------------------------
module calendar_date_stepper_core_test;
    import cds_pkg::*;

    localparam logic [2:0] KIND_SPARE   = 3'd7;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         CYCLE_LIMIT  = 30_000_000;
    localparam int         PRINT_LIMIT  = 30;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] amount;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
    } date_cmd_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
        logic        active;
        logic        valid;
    } date_beat_t;

    typedef struct packed {
        date_cmd_t  cmd;
        logic       typed;
        date_beat_t want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         kind;
    logic signed [12:0] amount;
    logic [4:0]         date_day;
    logic [3:0]         date_month;
    logic [11:0]        date_year;
    logic [4:0]         hour_value;
    logic               done;
    logic [4:0]         cur_day;
    logic [3:0]         cur_month;
    logic [11:0]        cur_year;
    logic [4:0]         cur_hour;
    logic               sim_on;
    logic               date_ok;

    logic [4:0]  cal_day    = 5'd1;
    logic [3:0]  cal_month  = 4'd1;
    logic [11:0] cal_year   = VALID_LO;
    logic [4:0]  cal_hour   = 5'd0;
    logic        cal_active = 1'b0;
    logic        hour_locked = 1'b0;

    date_beat_t pending_dates[$];
    dir_row_t   directed_cmds[$];
    date_beat_t seen_want;
    int         mismatch_count = 0;
    int         results_seen   = 0;
    int         beats_sent     = 0;
    int         cycle_count    = 0;
    int         kind_count[8];

    calendar_date_stepper_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .amount     (amount),
        .date_day   (date_day),
        .date_month (date_month),
        .date_year  (date_year),
        .hour_value (hour_value),
        .done       (done),
        .cur_day    (cur_day),
        .cur_month  (cur_month),
        .cur_year   (cur_year),
        .cur_hour   (cur_hour),
        .sim_on     (sim_on),
        .date_ok    (date_ok)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2)
        begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11)
        begin
            return 30;
        end
        return 31;
    endfunction

    function automatic void advance_one_day();
        int d;
        int m;
        d = int'(cal_day) + 1;
        if (d > days_in_month(int'(cal_month), int'(cal_year)))
        begin
            m = int'(cal_month) + 1;
            d = 1;
            if (m > int'(MONTHS))
            begin
                if (cal_year >= YEAR_MAX)
                begin
                    cal_day   = 5'd31;
                    cal_month = MONTHS;
                    return;
                end
                m        = 1;
                cal_year = cal_year + 12'd1;
            end
            cal_month = 4'(m);
        end
        cal_day = 5'(d);
    endfunction

    function automatic void retreat_one_day();
        int m;
        if (cal_day >= 5'd2)
        begin
            cal_day = cal_day - 5'd1;
            return;
        end
        if (cal_month <= 4'd1)
        begin
            if (cal_year == 12'd0)
            begin
                cal_day   = 5'd1;
                cal_month = 4'd1;
                return;
            end
            m        = int'(MONTHS);
            cal_year = cal_year - 12'd1;
        end
        else
        begin
            m = int'(cal_month) - 1;
        end
        cal_month = 4'(m);
        cal_day   = 5'(days_in_month(m, int'(cal_year)));
    endfunction

    function automatic void start_from_item(input date_cmd_t c);
        if (!cal_active)
        begin
            cal_day    = c.day;
            cal_month  = c.month;
            cal_year   = c.year;
            cal_active = 1'b1;
        end
    endfunction

    function automatic void roll_days(input date_cmd_t c, input int n);
        start_from_item(c);
        if (n >= 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                advance_one_day();
            end
        end
        else
        begin
            for (int i = 0; i < -n; i++)
            begin
                retreat_one_day();
            end
        end
    endfunction

    function automatic void roll_months(input date_cmd_t c, input int n);
        int idx;
        int len;
        start_from_item(c);
        idx = int'(cal_year) * int'(MONTHS) + int'(cal_month) - 1 + n;
        if (idx < 0)
        begin
            idx = 0;
        end
        if (idx > int'(MONTH_IDX_MAX))
        begin
            idx = int'(MONTH_IDX_MAX);
        end
        cal_year  = 12'(idx / int'(MONTHS));
        cal_month = 4'(idx % int'(MONTHS) + 1);
        len = days_in_month(int'(cal_month), int'(cal_year));
        if (int'(cal_day) > len)
        begin
            cal_day = 5'(len);
        end
    endfunction

    function automatic void roll_hours(input date_cmd_t c, input int n);
        int hv;
        if (!hour_locked)
        begin
            cal_hour    = c.hour;
            hour_locked = 1'b1;
        end
        hv = int'(cal_hour) + n;
        while (hv >= int'(HOURS_DAY))
        begin
            hv = hv - int'(HOURS_DAY);
            roll_days(c, 1);
        end
        while (hv < 0)
        begin
            hv = hv + int'(HOURS_DAY);
            roll_days(c, -1);
        end
        cal_hour = 5'(hv);
    endfunction

    function automatic date_beat_t predict_date(input date_cmd_t c);
        date_beat_t r;
        int         n;
        n = int'($signed(c.amount));
        case (c.kind)
            KIND_STEP_DAYS:
            begin
                roll_days(c, n);
            end
            KIND_STEP_MONTHS:
            begin
                roll_months(c, n);
            end
            KIND_STEP_HOURS:
            begin
                roll_hours(c, n);
            end
            KIND_SET_DATE, KIND_SET_DATE_HOUR:
            begin
                cal_day    = c.day;
                cal_month  = c.month;
                cal_year   = c.year;
                cal_active = 1'b1;
                if (c.kind == KIND_SET_DATE_HOUR)
                begin
                    cal_hour    = c.hour;
                    hour_locked = 1'b1;
                end
            end
            KIND_END_SIM:
            begin
                cal_active  = 1'b0;
                hour_locked = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.day    = cal_active ? cal_day : c.day;
        r.month  = cal_active ? cal_month : c.month;
        r.year   = cal_active ? cal_year : c.year;
        r.hour   = hour_locked ? cal_hour : c.hour;
        r.active = cal_active;
        r.valid  = r.year >= VALID_LO && r.year <= VALID_HI && r.month >= 4'd1
                   && r.month <= MONTHS && r.day >= 5'd1
                   && int'(r.day) <= days_in_month(int'(r.month), int'(r.year));
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] k, input int amt, input int d,
                                    input int m, input int y, input int h,
                                    input bit typed = 1'b0, input int wd = 0,
                                    input int wm = 0, input int wy = 0, input int wh = 0,
                                    input bit won = 1'b0, input bit wok = 1'b0);
        dir_row_t row;
        row.cmd.kind    = k;
        row.cmd.amount  = 13'(amt);
        row.cmd.day     = 5'(d);
        row.cmd.month   = 4'(m);
        row.cmd.year    = 12'(y);
        row.cmd.hour    = 5'(h);
        row.typed       = typed;
        row.want.day    = 5'(wd);
        row.want.month  = 4'(wm);
        row.want.year   = 12'(wy);
        row.want.hour   = 5'(wh);
        row.want.active = won;
        row.want.valid  = wok;
        directed_cmds.push_back(row);
    endfunction

    function automatic date_cmd_t random_command();
        date_cmd_t c;
        int        sel;
        int        y;
        int        m;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            c.kind = KIND_QUERY;
        else if (sel < 12)
            c.kind = KIND_SPARE;
        else if (sel < 38)
            c.kind = KIND_STEP_DAYS;
        else if (sel < 56)
            c.kind = KIND_STEP_MONTHS;
        else if (sel < 76)
            c.kind = KIND_STEP_HOURS;
        else if (sel < 86)
            c.kind = KIND_SET_DATE;
        else if (sel < 93)
            c.kind = KIND_SET_DATE_HOUR;
        else
            c.kind = KIND_END_SIM;

        sel = $urandom_range(0, 99);
        if (sel < 55)
            c.amount = 13'(int'($urandom_range(0, 100)) - 50);
        else if (sel < 85)
            c.amount = 13'(int'($urandom_range(0, 1000)) - 500);
        else if (sel < 97)
            c.amount = 13'(int'($urandom_range(0, 8)) - 4);
        else
            c.amount = 13'($urandom);

        sel = $urandom_range(0, 99);
        if (sel < 80)
        begin
            if (sel < 70)
                y = $urandom_range(1890, 2110);
            else if ($urandom_range(0, 1) == 0)
                y = $urandom_range(0, 3);
            else
                y = $urandom_range(4092, 4095);
            m = $urandom_range(1, 12);
            c.year  = 12'(y);
            c.month = 4'(m);
            if ($urandom_range(0, 3) == 0)
                c.day = 5'(days_in_month(m, y) - int'($urandom_range(0, 2)));
            else
                c.day = 5'($urandom_range(1, days_in_month(m, y)));
        end
        else
        begin
            c.day   = 5'($urandom);
            c.month = 4'($urandom);
            c.year  = 12'($urandom);
        end
        if ($urandom_range(0, 99) < 85)
            c.hour = 5'($urandom_range(0, 23));
        else
            c.hour = 5'($urandom_range(24, 31));
        return c;
    endfunction

    function automatic int pick_gap(input int idx);
        if (idx >= 600 && idx < 900)
        begin
            return 0;
        end
        if ($urandom_range(0, 99) < 21)
        begin
            return $urandom_range(1, 5);
        end
        return 0;
    endfunction

    task automatic issue_command(input date_cmd_t c, input date_beat_t want, input int gap);
        if (gap > 0)
        begin
            start      <= 1'b0;
            kind       <= 3'($urandom);
            amount     <= 13'($urandom);
            date_day   <= 5'($urandom);
            date_month <= 4'($urandom);
            date_year  <= 12'($urandom);
            hour_value <= 5'($urandom);
            repeat (gap) @(posedge clk);
        end
        kind       <= c.kind;
        amount     <= c.amount;
        date_day   <= c.day;
        date_month <= c.month;
        date_year  <= c.year;
        hour_value <= c.hour;
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_dates.push_back(want);
        kind_count[c.kind] = kind_count[c.kind] + 1;
        beats_sent = beats_sent + 1;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_dates.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("mismatch on result beat %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_dates.size() == 0)
            begin
                flag_mismatch("unexpected beat, pending count", 1, 0);
            end
            else
            begin
                seen_want = pending_dates.pop_front();
                if (cur_day !== seen_want.day)
                    flag_mismatch("cur_day", int'(cur_day), int'(seen_want.day));
                if (cur_month !== seen_want.month)
                    flag_mismatch("cur_month", int'(cur_month), int'(seen_want.month));
                if (cur_year !== seen_want.year)
                    flag_mismatch("cur_year", int'(cur_year), int'(seen_want.year));
                if (cur_hour !== seen_want.hour)
                    flag_mismatch("cur_hour", int'(cur_hour), int'(seen_want.hour));
                if (sim_on !== seen_want.active)
                    flag_mismatch("sim_on", int'(sim_on), int'(seen_want.active));
                if (date_ok !== seen_want.valid)
                    flag_mismatch("date_ok", int'(date_ok), int'(seen_want.valid));
            end
            results_seen <= results_seen + 1;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending_dates.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        date_cmd_t  c;
        date_beat_t w;
        int         directed_total;
        foreach (kind_count[i])
        begin
            kind_count[i] = 0;
        end
        rst_n      <= 1'b0;
        start      <= 1'b0;
        kind       <= KIND_QUERY;
        amount     <= '0;
        date_day   <= '0;
        date_month <= '0;
        date_year  <= '0;
        hour_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_row(KIND_QUERY, 0, 15, 6, 2024, 13, 1, 15, 6, 2024, 13, 0, 1);
        add_row(KIND_QUERY, 0, 31, 15, 4095, 31, 1, 31, 15, 4095, 31, 0, 0);
        add_row(KIND_SPARE, 0, 29, 2, 2000, 5, 1, 29, 2, 2000, 5, 0, 1);
        add_row(KIND_STEP_HOURS, 5, 10, 3, 2020, 22);
        add_row(KIND_END_SIM, 0, 1, 1, 1999, 7, 1, 1, 1, 1999, 7, 0, 1);
        add_row(KIND_STEP_HOURS, 1, 5, 5, 2005, 10);
        add_row(KIND_END_SIM, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(KIND_STEP_DAYS, 1, 31, 12, 2099, 0);
        add_row(KIND_STEP_DAYS, -1, 1, 1, 2000, 16);
        add_row(KIND_SET_DATE, 0, 28, 2, 1900, 9, 1, 28, 2, 1900, 9, 1, 1);
        add_row(KIND_STEP_DAYS, 1, 3, 7, 1950, 9);
        add_row(KIND_SET_DATE_HOUR, 0, 29, 2, 2000, 31, 1, 29, 2, 2000, 31, 1, 1);
        add_row(KIND_STEP_HOURS, 0, 12, 8, 2010, 4);
        add_row(KIND_SET_DATE, 0, 31, 1, 2024, 0, 1, 31, 1, 2024, 7, 1, 1);
        add_row(KIND_STEP_MONTHS, 1, 17, 9, 1988, 2);
        add_row(KIND_SET_DATE, 0, 25, 12, 4095, 0, 1, 25, 12, 4095, 7, 1, 0);
        add_row(KIND_STEP_DAYS, 4095, 2, 2, 2002, 2);
        add_row(KIND_STEP_MONTHS, 4095, 9, 9, 1999, 9);
        add_row(KIND_SET_DATE, 0, 5, 1, 0, 0, 1, 5, 1, 0, 7, 1, 0);
        add_row(KIND_STEP_DAYS, -4096, 20, 4, 2040, 20);
        add_row(KIND_STEP_MONTHS, -4096, 6, 6, 2006, 6);
        add_row(KIND_SET_DATE, 0, 31, 13, 2000, 0, 1, 31, 13, 2000, 7, 1, 0);
        add_row(KIND_STEP_DAYS, 1, 14, 11, 2011, 1);
        add_row(KIND_SET_DATE, 0, 0, 0, 2000, 0, 1, 0, 0, 2000, 7, 1, 0);
        add_row(KIND_STEP_DAYS, -1, 8, 8, 2008, 8);
        add_row(KIND_STEP_HOURS, -4096, 30, 4, 2030, 12);
        add_row(KIND_END_SIM, 0, 1, 1, 2100, 23, 1, 1, 1, 2100, 23, 0, 1);

        foreach (directed_cmds[i])
        begin
            w = predict_date(directed_cmds[i].cmd);
            if (directed_cmds[i].typed)
            begin
                w = directed_cmds[i].want;
            end
            issue_command(directed_cmds[i].cmd, w, pick_gap(-1));
        end
        directed_total = beats_sent;
        hold_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 400)
            begin
                hold_until_drained();
            end
            c = random_command();
            w = predict_date(c);
            issue_command(c, w, pick_gap(i));
        end
        start <= 1'b0;

        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d commands (%0d directed, %0d random), checked %0d result beats, %0d mismatches.",
                 beats_sent, directed_total, beats_sent - directed_total, results_seen,
                 mismatch_count);
        $display("Mix: query %0d, days %0d, months %0d, hours %0d, set %0d, set+hour %0d, end %0d, spare %0d.",
                 kind_count[KIND_QUERY], kind_count[KIND_STEP_DAYS],
                 kind_count[KIND_STEP_MONTHS], kind_count[KIND_STEP_HOURS],
                 kind_count[KIND_SET_DATE], kind_count[KIND_SET_DATE_HOUR],
                 kind_count[KIND_END_SIM], kind_count[KIND_SPARE]);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### calendar_date_stepper_core.f
rtl/cds_pkg.sv
rtl/calendar_date_stepper_core.sv
bench/calendar_date_stepper_core_test.sv
